// ===== rtl/prld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prld_pkg - shared definitions for the paletted run-length pixel decoder
// Mode codes, register indexes, field widths and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package prld_pkg;

	localparam int unsigned ColorW = 16;
	localparam int unsigned DimW   = 8;
	localparam int unsigned CountW = 16;
	localparam int unsigned PalIdxW = 4;
	localparam int unsigned PalDepth = 16;
	localparam int unsigned RunW   = 5;   // run length 1..16

	// Input item modes.
	localparam logic [1:0] MODE_PALETTE = 2'd0;
	localparam logic [1:0] MODE_START   = 2'd1;
	localparam logic [1:0] MODE_RUN     = 2'd2;
	localparam logic [1:0] MODE_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic pal_wr;      // write the palette entry of the accepted item
		logic clear_sent;  // start of a new image
		logic load_run;    // capture colour, run length and pixel total
		logic next_pix;    // load the next pixel into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic room;        // pixel counter is still below the image total
		logic last;        // pixel on show is the last of its run
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/palette_rle_pixel_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// palette_rle_pixel_decoder - run-length decoder for 4-bit paletted images
// Expands run bytes into 16-bit pixel colours looked up in a 16-entry
// palette, clamped to image_width * image_height pixels per image.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | in_valid/in_stall  | mode, palette_index,
//           |           |                    | palette_color, run_byte
//  output   | out       | out_valid/out_stall| pixel_color, run_last, image_done
//  config   | in        | cfg_write          | cfg_index, cfg_data
//
// A run byte goes through setup (capture, then the clamp check) followed
// by one emitted pixel per cycle while the output is not stalled, through
// the single output register that the run walks through.
// Reset clears the controller, the pixel counter and both size registers;
// the palette holds nothing defined until it is written.
// A stalled output holds the current pixel and pauses the run; no further
// input transaction is taken until the run has been fully delivered.
// ----------------------------------------------------------------------------
module palette_rle_pixel_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration write port.
	input  wire logic                              cfg_write,
	input  wire logic                              cfg_index,
	input  wire logic [prld_pkg::DimW-1:0]         cfg_data,
	// Input channel.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        mode,
	input  wire logic [prld_pkg::PalIdxW-1:0]      palette_index,
	input  wire logic [prld_pkg::ColorW-1:0]       palette_color,
	input  wire logic [7:0]                        run_byte,
	// Output channel.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [prld_pkg::ColorW-1:0]            pixel_color,
	output logic                                   run_last,
	output logic                                   image_done
);
	import prld_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller owns the handshakes; it accepts a transaction only when
	// idle and raises out_valid for as long as a pixel sits in the output
	// register.
	prld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds every stored value and forms each pixel, including
	// the end-of-run and end-of-image flags, as it is loaded for output.
	prld_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.palette_index(palette_index),
		.palette_color(palette_color),
		.run_byte     (run_byte),
		.cmd          (cmd),
		.sts          (sts),
		.pixel_color  (pixel_color),
		.run_last     (run_last),
		.image_done   (image_done)
	);

endmodule
`default_nettype wire

// ===== rtl/prld_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prld_ctrl - sequencing controller
// Accepts one input transaction at a time, issues datapath commands and
// walks through the pixels of a run, one per output transaction.
// ----------------------------------------------------------------------------
module prld_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     mode,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire prld_pkg::sts_t sts,
	output prld_pkg::cmd_t      cmd
);
	import prld_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_fire;
	logic       out_fire;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid && !in_stall;
	assign out_fire  = out_valid && !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (mode)
						MODE_PALETTE: cmd.pal_wr = 1'b1;
						MODE_START:   cmd.clear_sent = 1'b1;
						MODE_RUN: begin
							cmd.load_run = 1'b1;
							state_d      = ST_SETUP;
						end
						MODE_UNUSED: ;
						default: ;
					endcase
				end
			end
			ST_SETUP: begin
				// A run that starts at or past the image total emits nothing.
				if (sts.room) begin
					cmd.next_pix = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_fire) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_pix = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/prld_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prld_dp - decoder datapath
// Holds the image size registers, the palette, the pixel counter, the
// current run and the output register.
// ----------------------------------------------------------------------------
module prld_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic                             cfg_index,
	input  wire logic [prld_pkg::DimW-1:0]        cfg_data,
	input  wire logic [prld_pkg::PalIdxW-1:0]     palette_index,
	input  wire logic [prld_pkg::ColorW-1:0]      palette_color,
	input  wire logic [7:0]                       run_byte,
	input  wire prld_pkg::cmd_t                   cmd,
	output prld_pkg::sts_t                        sts,
	output logic [prld_pkg::ColorW-1:0]           pixel_color,
	output logic                                  run_last,
	output logic                                  image_done
);
	import prld_pkg::*;

	logic [DimW-1:0]   width_q;
	logic [DimW-1:0]   height_q;
	logic [ColorW-1:0] palette_q [PalDepth];
	logic [CountW-1:0] sent_q;
	logic [CountW-1:0] total_q;
	logic [RunW-1:0]   rem_q;
	logic [ColorW-1:0] color_q;
	logic [CountW-1:0] sent_inc;
	logic              hit_total;

	assign sent_inc  = sent_q + CountW'(1);
	assign hit_total = (sent_inc == total_q);

	assign sts.room = (sent_q < total_q);
	assign sts.last = run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pal_wr) begin
			palette_q[palette_index] <= palette_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= '0;
		end else if (cmd.clear_sent) begin
			sent_q <= '0;
		end else if (cmd.next_pix) begin
			sent_q <= sent_inc;
		end
	end

	// Run capture and output register: payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load_run) begin
			color_q <= palette_q[run_byte[7:4]];
			rem_q   <= RunW'(run_byte[3:0]) + RunW'(1);
			total_q <= CountW'(width_q) * CountW'(height_q);
		end else if (cmd.next_pix) begin
			rem_q <= rem_q - RunW'(1);
		end
		if (cmd.next_pix) begin
			pixel_color <= color_q;
			run_last    <= (rem_q == RunW'(1)) || hit_total;
			image_done  <= hit_total;
		end
	end

endmodule
`default_nettype wire

// ===== sim/palette_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_rle_pixel_decoder_tb - self-checking bench for the run-length decoder
// Drives palette writes, image starts and run bytes through the input channel,
// predicts every pixel from a behavioural copy of the decoder and compares the
// output channel against it, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module palette_rle_pixel_decoder_tb;

	import prld_pkg::*;

	// This margin covers a run that was clamped to nothing and is still being
	// retired.
	localparam int unsigned SETTLE_CYCLES = 24;
	// Cycles without any accepted transaction or configuration write before the run is abandoned.
	localparam int unsigned QUIET_LIMIT   = 1000;

	typedef struct packed {
		logic [ColorW-1:0] color;
		logic              last;
		logic              done;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [DimW-1:0]       cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode = MODE_PALETTE;
	logic [PalIdxW-1:0]    palette_index = '0;
	logic [ColorW-1:0]     palette_color = '0;
	logic [7:0]            run_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ColorW-1:0]     pixel_color;
	logic                  run_last;
	logic                  image_done;

	// Behavioural copy of the decoder state, updated on accepted transactions.
	logic [ColorW-1:0]     palette_copy [PalDepth];
	logic [CountW-1:0]     pixels_done_copy = '0;
	logic [DimW-1:0]       width_copy = '0;
	logic [DimW-1:0]       height_copy = '0;
	pixel_t                pending_pixels [$];

	int unsigned           fail_count = 0;
	int unsigned           quiet_cycles = 0;
	int unsigned           stall_hold = 0;
	bit                    sender_gaps = 1'b1;
	bit                    receiver_stalls = 1'b1;

	palette_rle_pixel_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.run_byte      (run_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_color   (pixel_color),
		.run_last      (run_last),
		.image_done    (image_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Works out the pixels that one accepted input transaction should produce
	// and queues them. Runs are clamped to the pixels left in the image, and
	// the total is taken from the size registers as they stand right now.
	task automatic expand_run(input logic [1:0] m, input logic [PalIdxW-1:0] idx,
			input logic [ColorW-1:0] color, input logic [7:0] rb);
		int unsigned total;
		int unsigned count;
		int unsigned avail;
		int unsigned emit;
		int unsigned sent;
		pixel_t      px;
		case (m)
			MODE_PALETTE: begin
				palette_copy[idx] = color;
			end
			MODE_START: begin
				pixels_done_copy = '0;
			end
			MODE_RUN: begin
				total = width_copy;
				total = total * height_copy;
				count = rb[3:0];
				count = count + 1;
				sent  = pixels_done_copy;
				avail = (sent < total) ? total - sent : 0;
				emit  = (count < avail) ? count : avail;
				for (int unsigned k = 0; k < emit; k++) begin
					sent++;
					px.color = palette_copy[rb[7:4]];
					px.last  = (k + 1 == emit);
					px.done  = (sent == total);
					pending_pixels.push_back(px);
				end
				pixels_done_copy = sent[CountW-1:0];
			end
			default: begin
				// The unused mode leaves everything as it was.
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Monitoring and checking
	// ------------------------------------------------------------------------

	// Everything is sampled at the rising edge, before the block's own
	// updates at that edge land. Inputs are taken first, so an expectation is
	// always queued before its pixel could possibly come out.
	always @(posedge clk) begin
		if (!arst_n) begin
			pixels_done_copy = '0;
			width_copy       = '0;
			height_copy      = '0;
			pending_pixels.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_copy = cfg_data;
				end else begin
					height_copy = cfg_data;
				end
			end
			if (in_valid && !in_stall) begin
				expand_run(mode, palette_index, palette_color, run_byte);
			end
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					$error("unexpected pixel: pixel_color %h run_last %b image_done %b",
						pixel_color, run_last, image_done);
					fail_count++;
				end else begin
					if (pixel_color !== pending_pixels[0].color) begin
						$error("pixel_color: expected %h, got %h",
							pending_pixels[0].color, pixel_color);
						fail_count++;
					end
					if (run_last !== pending_pixels[0].last) begin
						$error("run_last: expected %b, got %b",
							pending_pixels[0].last, run_last);
						fail_count++;
					end
					if (image_done !== pending_pixels[0].done) begin
						$error("image_done: expected %b, got %b",
							pending_pixels[0].done, image_done);
						fail_count++;
					end
					void'(pending_pixels.pop_front());
				end
			end
		end
	end

	// A run that stops making progress altogether is a hang: give up on it.
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver back-pressure
	// ------------------------------------------------------------------------

	// Mostly no stall or a short one, now and then a long one that holds a
	// pixel on the output for a good while.
	always @(negedge clk) begin
		if (!receiver_stalls) begin
			out_stall = 1'b0;
			stall_hold = 0;
		end else if (stall_hold != 0) begin
			stall_hold--;
			out_stall = 1'b1;
		end else begin
			case ($urandom_range(19, 0))
				0, 1, 2, 3, 4, 5: begin
					out_stall = 1'b1;
					stall_hold = $urandom_range(2, 0);
				end
				6: begin
					out_stall = 1'b1;
					stall_hold = $urandom_range(30, 8);
				end
				default: begin
					out_stall = 1'b0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers; every one of them starts and ends on a falling edge
	// ------------------------------------------------------------------------

	function automatic int unsigned sender_gap();
		int unsigned pick;
		if (!sender_gaps) begin
			return 0;
		end
		pick = $urandom_range(99, 0);
		if (pick < 60) begin
			return 0;
		end else if (pick < 94) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Offers one input transaction and holds it until the block takes it.
	// Valid stays high on return so back-to-back transactions need no gap.
	task automatic send_item(input logic [1:0] m, input logic [PalIdxW-1:0] idx,
			input logic [ColorW-1:0] color, input logic [7:0] rb);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode          = m;
		palette_index = idx;
		palette_color = color;
		run_byte      = rb;
		in_valid      = 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
	endtask

	// Stops offering work and waits until every predicted pixel has come.
	task automatic drain_pixels();
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Drains and then lets a clamped run that yields nothing finish as well,
	// so that the size registers can be changed safely.
	task automatic settle();
		drain_pixels();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
		in_valid  = 1'b0;
		cfg_write = 1'b1;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data  = w;
		@(negedge clk);
		cfg_index = REG_IMAGE_HEIGHT;
		cfg_data  = h;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic send_run(input logic [7:0] rb);
		send_item(MODE_RUN, PalIdxW'($urandom), ColorW'($urandom), rb);
	endtask

	task automatic send_start();
		send_item(MODE_START, PalIdxW'($urandom), ColorW'($urandom), 8'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Loads only the entries that the directed tests use. The index and
	// colour bits each see both values across these four writes.
	task automatic test_palette_setup();
		send_item(MODE_PALETTE, 4'd0,  16'h0000, 8'h00);
		send_item(MODE_PALETTE, 4'd15, 16'hFFFF, 8'hFF);
		send_item(MODE_PALETTE, 4'd5,  16'h5A5A, 8'h0F);
		send_item(MODE_PALETTE, 4'd10, 16'hA5A5, 8'hF0);
	endtask

	// With either dimension at zero the image holds no pixels at all.
	task automatic test_zero_size();
		send_start();
		send_run(8'hF0);
		settle();
		write_size(8'd255, 8'd0);
		send_run(8'h0F);
		settle();
		write_size(8'd0, 8'd255);
		send_run(8'h5F);
	endtask

	// Shortest and longest runs on the largest image, the unused mode in the
	// middle of an image, and a palette entry rewritten between runs.
	task automatic test_run_lengths();
		settle();
		write_size(8'd255, 8'd255);
		send_start();
		send_run(8'h00);
		send_run(8'hFF);
		send_item(MODE_UNUSED, 4'd15, 16'hFFFF, 8'hFF);
		send_run(8'h5F);
		send_run(8'hA7);
		send_item(MODE_PALETTE, 4'd5, 16'h1234, 8'h55);
		send_run(8'h52);
		// Hold off until the whole image so far has come out.
		drain_pixels();
	endtask

	// A run cut short at the end of the image, one past the end that yields
	// nothing, and a run that fills a fresh image exactly.
	task automatic test_clamp();
		settle();
		write_size(8'd3, 8'd2);
		send_start();
		send_run(8'hA4);
		send_run(8'h53);
		send_run(8'h0F);
		send_start();
		send_run(8'hF5);
	endtask

	// The total is recomputed on every run byte, so shrinking the image
	// below what has gone out stops it, and growing it lets a few more out.
	task automatic test_size_change();
		settle();
		write_size(8'd4, 8'd4);
		send_start();
		send_run(8'h5F);
		settle();
		write_size(8'd2, 8'd2);
		send_run(8'hAF);
		settle();
		write_size(8'd9, 8'd2);
		send_run(8'hF3);
	endtask

	// Several images of different sizes, each a start followed mostly by run
	// bytes with random content, with palette rewrites, restarts, unused-mode
	// transactions and full drains sprinkled in.
	task automatic test_random_images();
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		settle();
		for (int unsigned i = 0; i < PalDepth; i++) begin
			send_item(MODE_PALETTE, PalIdxW'(i), ColorW'($urandom), 8'($urandom));
		end
		for (int unsigned phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					w = 1;
					h = 1;
				end
				1: begin
					w = 255;
					h = 255;
				end
				2: begin
					w = 255;
					h = $urandom_range(3, 1);
				end
				default: begin
					w = $urandom_range(12, 1);
					h = $urandom_range(12, 1);
				end
			endcase
			settle();
			// Every third image runs flat out on both sides.
			sender_gaps     = (phase % 3 != 2);
			receiver_stalls = (phase % 3 != 2);
			write_size(DimW'(w), DimW'(h));
			send_start();
			for (int unsigned n = 0; n < 30; n++) begin
				pick = $urandom_range(99, 0);
				if (pick < 78) begin
					send_run(8'($urandom));
				end else if (pick < 86) begin
					send_item(MODE_PALETTE, PalIdxW'($urandom), ColorW'($urandom),
						8'($urandom));
				end else if (pick < 94) begin
					send_start();
				end else if (pick < 97) begin
					send_item(MODE_UNUSED, PalIdxW'($urandom), ColorW'($urandom),
						8'($urandom));
				end else begin
					drain_pixels();
				end
			end
		end
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------------

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_palette_setup();
		test_zero_size();
		test_run_lengths();
		test_clamp();
		test_size_change();
		test_random_images();

		// Let the last pixels out, then give the block time to go quiet.
		drain_pixels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/prld_pkg.sv
rtl/prld_ctrl.sv
rtl/prld_dp.sv
rtl/palette_rle_pixel_decoder.sv
sim/palette_rle_pixel_decoder_tb.sv
